>>> rtl/fifo_id_allocator_unit_defines.svh
// assertion macros for the identifier allocator
`ifndef FIFO_ID_ALLOCATOR_UNIT_DEFINES_SVH
`define FIFO_ID_ALLOCATOR_UNIT_DEFINES_SVH

`ifndef SYNTH

// property that must hold at every clock edge outside reset
`define FIA_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next cycle
`define FIA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define FIA_ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define FIA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

>>> rtl/fia_pkg.sv
// shared types, constants and helpers of the identifier allocator
package fia_pkg;

   // identifier range and free ring size
   localparam int ID_LOW     = 100;
   localparam int ID_HIGH    = 1000;
   localparam int RING_DEPTH = 1024;

   // widths
   localparam int ID_W    = 10;
   localparam int FRESH_W = ID_W + 1;
   localparam int PTR_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W   = $clog2(RING_DEPTH + 1);

   // request modes
   localparam logic MODE_ALLOC   = 1'b0;
   localparam logic MODE_RELEASE = 1'b1;

   // response status codes
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_NONE = 2'd1;
   localparam logic [1:0] STATUS_DROP = 2'd2;

   typedef struct packed {
      logic            mode;
      logic [ID_W-1:0] released_id;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0] granted_id;
      logic [1:0]      status;
   } rsp_type;

   // response handed from the control to the output register
   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } rsp_push_type;

   // ring pointer advance with wrap
   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] nxt;
      if (ptr == PTR_W'(RING_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + 1'b1;
      end
      return nxt;
   endfunction

endpackage

>>> rtl/fia_ring_ram.sv
// single port-pair synchronous ram holding released identifiers
module fia_ring_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 10,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/fia_ctrl.sv
// request decode, fresh counter, ring pointers and sequencing
`include "fifo_id_allocator_unit_defines.svh"

module fia_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  fia_pkg::req_type                 req_data,
   input  logic                             out_free,
   output fia_pkg::rsp_push_type            push,
   output logic                             ram_wr_en,
   output logic [fia_pkg::PTR_W-1:0]        ram_wr_addr,
   output logic [fia_pkg::ID_W-1:0]         ram_wr_data,
   output logic                             ram_rd_en,
   output logic [fia_pkg::PTR_W-1:0]        ram_rd_addr,
   input  logic [fia_pkg::ID_W-1:0]         ram_rd_data
);
   import fia_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_READ = 1'b1;

   logic               state_ff, state_in;
   logic [FRESH_W-1:0] fresh_ff, fresh_in;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               accept;

   // one request at a time; output register must have room
   assign req_stall = (state_ff != S_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;

   // next state and ram commands
   always_comb begin
      state_in    = state_ff;
      fresh_in    = fresh_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      push        = '0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = tail_ff;
      ram_wr_data = req_data.released_id;
      ram_rd_en   = 1'b0;
      ram_rd_addr = head_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_data.mode == MODE_ALLOC) begin
                  if (fresh_ff <= FRESH_W'(ID_HIGH)) begin
                     // fresh identifiers come first
                     push.valid          = 1'b1;
                     push.rsp.granted_id = fresh_ff[ID_W-1:0];
                     push.rsp.status     = STATUS_OK;
                     fresh_in            = fresh_ff + 1'b1;
                  end else if (count_ff != '0) begin
                     // pop the ring front, answer once the ram returns it
                     ram_rd_en = 1'b1;
                     head_in   = ring_next(head_ff);
                     count_in  = count_ff - 1'b1;
                     state_in  = S_READ;
                  end else begin
                     push.valid      = 1'b1;
                     push.rsp.status = STATUS_NONE;
                  end
               end else begin
                  if (count_ff == CNT_W'(RING_DEPTH)) begin
                     push.valid      = 1'b1;
                     push.rsp.status = STATUS_DROP;
                  end else begin
                     // append released identifier at the ring back
                     ram_wr_en       = 1'b1;
                     tail_in         = ring_next(tail_ff);
                     count_in        = count_ff + 1'b1;
                     push.valid      = 1'b1;
                     push.rsp.status = STATUS_OK;
                  end
               end
            end
         end
         S_READ: begin
            push.valid          = 1'b1;
            push.rsp.granted_id = ram_rd_data;
            push.rsp.status     = STATUS_OK;
            state_in            = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fresh_ff <= FRESH_W'(ID_LOW);
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         fresh_ff <= fresh_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // checks
   `FIA_ASSERT_ALWAYS(a_count_bound, clock, reset,
      count_ff <= CNT_W'(RING_DEPTH), "ring count over depth")
   `FIA_ASSERT_ALWAYS(a_no_rw_overlap, clock, reset,
      !(ram_wr_en && ram_rd_en), "ram read and write overlap")
   `FIA_ASSERT_ALWAYS(a_read_has_room, clock, reset,
      (state_ff != S_READ) || out_free, "ring read with full output")
   `FIA_ASSERT_NEXT(a_pop_then_read, clock, reset,
      ram_rd_en, state_ff == S_READ, "ring pop not followed by read state")

endmodule

>>> rtl/fifo_id_allocator_unit.sv
// Identifier allocator with a first-in first-out free list.
// Request channel (req_valid, req_stall, req_data): mode 0 allocates an identifier,
// mode 1 appends req_data.released_id to the back of the free list.
// Response channel (rsp_valid, rsp_stall, rsp_data): exactly one response per
// request, in request order: granted_id and status (ok, none free, release dropped).
// An allocation served from the released-identifier ring answers later than other
// requests, since the ring ram has a registered read port and the control passes
// through its read state before the response is pushed.
// Throughput: one request per cycle while the output register has room, but a ring
// allocation holds off the next request while its ram read completes.
// Reset (synchronous, active high) sets the fresh counter to the low bound and
// empties the ring; ram contents are not cleared and need no sweep.
// When the receiver stalls, the response waits in the output register and
// req_stall rises until that response is taken.
module fifo_id_allocator_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  fia_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fia_pkg::rsp_type rsp_data
);
   import fia_pkg::*;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff;
   logic             out_free;
   rsp_push_type     push;
   logic             ram_wr_en;
   logic [PTR_W-1:0] ram_wr_addr;
   logic [ID_W-1:0]  ram_wr_data;
   logic             ram_rd_en;
   logic [PTR_W-1:0] ram_rd_addr;
   logic [ID_W-1:0]  ram_rd_data;

   // output register is free when empty or being taken
   assign out_free = !rsp_valid_ff || !rsp_stall;

   fia_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .out_free    (out_free),
      .push        (push),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   fia_ring_ram #(
      .DEPTH (RING_DEPTH),
      .WIDTH (ID_W),
      .AW    (PTR_W)
   ) u_ring_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // output valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (push.valid) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (push.valid) begin
         rsp_data_ff <= push.rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> test/tb_fifo_id_allocator_unit.sv
// testbench for the fifo identifier allocator: free-list predictor and response checks
module tb_fifo_id_allocator_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import fia_pkg::*;

   // free-list predictor and expected response store
   class id_grant_ledger;
      logic [FRESH_W-1:0] next_fresh_id;
      logic [ID_W-1:0]    queued_ids[$];
      rsp_type            expected_grants[$];
      int                 mismatches;

      function new();
         next_fresh_id = FRESH_W'(ID_LOW);
         mismatches    = 0;
      endfunction

      // fresh identifiers first, then released ones in arrival order
      function rsp_type predict_grant(input req_type item);
         rsp_type grant;
         grant.granted_id = '0;
         grant.status     = STATUS_OK;
         if (item.mode == MODE_ALLOC) begin
            if (next_fresh_id <= FRESH_W'(ID_HIGH)) begin
               grant.granted_id = next_fresh_id[ID_W-1:0];
               next_fresh_id    = next_fresh_id + 1'b1;
            end else if (queued_ids.size() != 0) begin
               grant.granted_id = queued_ids.pop_front();
            end else begin
               grant.status = STATUS_NONE;
            end
         end else begin
            if (queued_ids.size() >= RING_DEPTH) begin
               grant.status = STATUS_DROP;
            end else begin
               queued_ids.push_back(item.released_id);
            end
         end
         return grant;
      endfunction

      function void note_request(input req_type item);
         expected_grants.push_back(predict_grant(item));
      endfunction

      function void check_response(input rsp_type actual);
         rsp_type want;
         if (expected_grants.size() == 0) begin
            $error("response with no request outstanding: granted_id %0d status %0d",
                   actual.granted_id, actual.status);
            mismatches++;
            return;
         end
         want = expected_grants.pop_front();
         if (actual.granted_id !== want.granted_id) begin
            $error("granted_id expected %0d actual %0d", want.granted_id, actual.granted_id);
            mismatches++;
         end
         if (actual.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, actual.status);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_grants.size();
      endfunction

      function int ring_level();
         return queued_ids.size();
      endfunction

      // identifiers an allocation could still hand out
      function int free_count();
         int fresh_left;
         fresh_left = (next_fresh_id <= FRESH_W'(ID_HIGH)) ? (ID_HIGH + 1 - next_fresh_id) : 0;
         return fresh_left + queued_ids.size();
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int req_gap_pct = 0;
   int rsp_stall_pct = 0;
   int hold_requests = 0;
   int holds_started = 0;
   int hold_left = 0;

   id_grant_ledger ledger;

   fifo_id_allocator_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // receiver: random stalls, or a long hold-off when one is asked for
   always @(posedge clock) begin
      if (holds_started != hold_requests) begin
         holds_started = hold_requests;
         hold_left     = 48;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // handshake monitor: check responses, note accepted requests
   always @(posedge clock) begin
      if (!reset && ledger != null) begin
         if (rsp_valid && !rsp_stall) begin
            ledger.check_response(rsp_data);
         end
         if (req_valid && !req_stall) begin
            ledger.note_request(req_data);
         end
      end
   end

   // offer one request, with a random gap ahead of it
   task automatic offer_request(input req_type item);
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic request_alloc();
      req_type item;
      item.mode        = MODE_ALLOC;
      item.released_id = ID_W'($urandom);
      offer_request(item);
   endtask

   task automatic request_release(input logic [ID_W-1:0] id);
      req_type item;
      item.mode        = MODE_RELEASE;
      item.released_id = id;
      offer_request(item);
   endtask

   task automatic request_random(input int alloc_pct);
      if ($urandom_range(99) < alloc_pct) begin
         request_alloc();
      end else begin
         request_release(ID_W'($urandom));
      end
   endtask

   // hold the sender until every response is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // run limit
   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int drain_count;
      int fill_count;
      ledger = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // sender gaps light, receiver stalls heavy
      req_gap_pct   = 29;
      rsp_stall_pct = 75;

      // directed: fresh ids in order, edge ids, never-allocated and duplicate releases
      repeat (3) request_alloc();
      request_release('0);
      request_release('1);
      request_release(10'h2AA);
      request_release(10'h155);
      request_release(10'h155);
      request_release(10'd101);
      repeat (2) request_alloc();

      // long receiver hold-off while requests keep coming, so the input backs up
      hold_requests++;
      repeat (20) request_alloc();
      wait_drained();

      // mostly allocations, drawing on the fresh range
      repeat (700) request_random(98);

      // sender gaps heavy, receiver stalls light
      req_gap_pct   = 75;
      rsp_stall_pct = 29;
      repeat (120) request_random(80);

      // empty the free list and keep asking
      wait_drained();
      drain_count = ledger.free_count() + 6;
      repeat (drain_count) request_alloc();

      // no idling: fill the ring past full under a hold-off, then mix
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      wait_drained();
      fill_count = RING_DEPTH - ledger.ring_level() + 4;
      hold_requests++;
      repeat (fill_count) request_release(ID_W'($urandom));
      repeat (60) request_random(50);

      wait_drained();
      repeat (4) @(posedge clock);
      if (ledger.mismatches == 0 && ledger.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
